// ===== sv/go_back_n_sender_window_assert.svh =====
// Assertion macros for the sender window checker.
`ifndef GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_ASSERT_SVH

// Consequent checked at the same clock edge as the antecedent.
`define GBNSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define GBNSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gbnsw_pkg.sv =====
// Types, constants and the microcode table of the Go-Back-N sender window.
`timescale 1ns / 1ps

package gbnsw_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int ID_WIDTH_DEF   = 16;
    localparam int WIN_W          = 7;
    localparam int TICK_W         = 32;
    localparam int SLOW_LIMIT     = 5;
    localparam int UPC_W          = 5;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 32'd1000;
    localparam logic [1:0]        ACK_CODE_CLOSE = 2'd1;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_OFFER,
        CMD_ACK,
        CMD_TICK
    } cmd_t;

    typedef enum logic [2:0] {
        K_SEND,
        K_RESEND,
        K_REFUSED,
        K_ACK,
        K_STALE,
        K_DONE,
        K_IDLE
    } kind_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_SEND_DATA,
        OP_SEND_CLOSE,
        OP_RESEND,
        OP_END_BURST,
        OP_ACK_DEC,
        OP_ACK_UPDATE,
        OP_SET_DONE,
        OP_TICK_COUNT,
        OP_TIMEOUT
    } op_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_LAST,
        EM_RESEND
    } emit_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_REFUSE_PRE,
        C_RESEND_ACT,
        C_FIN,
        C_NO_ROOM,
        C_NOT_SETTLED,
        C_NO_BURST,
        C_LOOP,
        C_STALE,
        C_CLOSE_ACK,
        C_DONE,
        C_NOT_EXPIRED,
        C_SETTLED
    } cond_t;

    typedef struct packed {
        op_t   op;
        emit_t em;
        kind_t kind;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // Microcode addresses. Fall-through steps rely on consecutive numbering.
    localparam upc_t A_FETCH        = 5'd0;
    localparam upc_t A_START        = 5'd1;
    localparam upc_t A_OFFER        = 5'd2;
    localparam upc_t A_OFFER_ACT    = 5'd3;
    localparam upc_t A_OFFER_FIN    = 5'd4;
    localparam upc_t A_OFFER_ROOM   = 5'd5;
    localparam upc_t A_SEND         = 5'd6;
    localparam upc_t A_CLOSE        = 5'd7;
    localparam upc_t A_SEND_CLOSE   = 5'd8;
    localparam upc_t A_REFUSE       = 5'd9;
    localparam upc_t A_OBURST       = 5'd10;
    localparam upc_t A_ORESEND      = 5'd11;
    localparam upc_t A_BEND         = 5'd12;
    localparam upc_t A_OBEND_REFUSE = 5'd13;
    localparam upc_t A_ACK          = 5'd14;
    localparam upc_t A_ACK_UPD      = 5'd15;
    localparam upc_t A_ACK_TAKEN    = 5'd16;
    localparam upc_t A_DONE         = 5'd17;
    localparam upc_t A_STALE        = 5'd18;
    localparam upc_t A_TICK         = 5'd19;
    localparam upc_t A_TICK_CNT     = 5'd20;
    localparam upc_t A_TICK_OUT     = 5'd21;
    localparam upc_t A_TIMEOUT      = 5'd22;
    localparam upc_t A_TBURST       = 5'd23;
    localparam upc_t A_TRESEND      = 5'd24;
    localparam upc_t A_TBEND        = 5'd25;
    localparam upc_t A_IDLE         = 5'd26;

    function automatic upc_t dispatch(input cmd_t cmd);
        upc_t a;
        case (cmd)
            CMD_START: a = A_START;
            CMD_OFFER: a = A_OFFER;
            CMD_ACK:   a = A_ACK;
            CMD_TICK:  a = A_TICK;
            default:   a = A_FETCH;
        endcase
        return a;
    endfunction

    function automatic uword_t ucode(input upc_t addr);
        uword_t w;
        case (addr)
            A_FETCH:        w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_DISPATCH,    A_FETCH};
            A_START:        w = '{OP_CLEAR,      EM_LAST,   K_IDLE,    C_JUMP,        A_FETCH};
            A_OFFER:        w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_REFUSE_PRE,  A_REFUSE};
            A_OFFER_ACT:    w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_RESEND_ACT,  A_OBURST};
            A_OFFER_FIN:    w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_FIN,         A_CLOSE};
            A_OFFER_ROOM:   w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_NO_ROOM,     A_REFUSE};
            A_SEND:         w = '{OP_SEND_DATA,  EM_LAST,   K_SEND,    C_JUMP,        A_FETCH};
            A_CLOSE:        w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_NOT_SETTLED, A_REFUSE};
            A_SEND_CLOSE:   w = '{OP_SEND_CLOSE, EM_LAST,   K_SEND,    C_JUMP,        A_FETCH};
            A_REFUSE:       w = '{OP_NOP,        EM_LAST,   K_REFUSED, C_JUMP,        A_FETCH};
            A_OBURST:       w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_NO_BURST,    A_OBEND_REFUSE};
            A_ORESEND:      w = '{OP_RESEND,     EM_RESEND, K_RESEND,  C_LOOP,        A_BEND};
            A_BEND:         w = '{OP_END_BURST,  EM_NONE,   K_IDLE,    C_JUMP,        A_FETCH};
            A_OBEND_REFUSE: w = '{OP_END_BURST,  EM_NONE,   K_IDLE,    C_JUMP,        A_REFUSE};
            A_ACK:          w = '{OP_ACK_DEC,    EM_NONE,   K_IDLE,    C_STALE,       A_STALE};
            A_ACK_UPD:      w = '{OP_ACK_UPDATE, EM_NONE,   K_IDLE,    C_CLOSE_ACK,   A_DONE};
            A_ACK_TAKEN:    w = '{OP_NOP,        EM_LAST,   K_ACK,     C_JUMP,        A_FETCH};
            A_DONE:         w = '{OP_SET_DONE,   EM_LAST,   K_DONE,    C_JUMP,        A_FETCH};
            A_STALE:        w = '{OP_NOP,        EM_LAST,   K_STALE,   C_JUMP,        A_FETCH};
            A_TICK:         w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_DONE,        A_IDLE};
            A_TICK_CNT:     w = '{OP_TICK_COUNT, EM_NONE,   K_IDLE,    C_NOT_EXPIRED, A_IDLE};
            A_TICK_OUT:     w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_SETTLED,     A_IDLE};
            A_TIMEOUT:      w = '{OP_TIMEOUT,    EM_NONE,   K_IDLE,    C_NEXT,        A_FETCH};
            A_TBURST:       w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_NO_BURST,    A_TBEND};
            A_TRESEND:      w = '{OP_RESEND,     EM_RESEND, K_RESEND,  C_LOOP,        A_BEND};
            A_TBEND:        w = '{OP_END_BURST,  EM_NONE,   K_IDLE,    C_NEXT,        A_FETCH};
            A_IDLE:         w = '{OP_NOP,        EM_LAST,   K_IDLE,    C_JUMP,        A_FETCH};
            default:        w = '{OP_NOP,        EM_NONE,   K_IDLE,    C_JUMP,        A_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/go_back_n_sender_window.sv =====
// Go-Back-N sender window with AIMD congestion window, run by a microcode sequencer.
// Each command runs as a sequence of microcode steps, and every result it emits is registered;
// a retransmit burst repeats one step, giving one result per packet that it resends.
// Results stall the sequencer only on steps that emit; commands wait in the fetch step.
// Reset (rst_n low, asynchronous) clears all window state (both windows start at one) and sets timeout_reg to 1000.
`timescale 1ns / 1ps

module go_back_n_sender_window import gbnsw_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [TICK_W-1:0]   cfg_wr_data,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [1:0]          command,
    input  logic                final_packet,
    input  logic [ID_WIDTH-1:0] ack_id,
    input  logic [1:0]          ack_code,
    input  logic [WIN_W-1:0]    ack_window,
    output logic                res_valid,
    input  logic                res_ready,
    output kind_t               kind,
    output logic [ID_WIDTH-1:0] packet_id,
    output logic                closing_flag,
    output logic                slow_pace,
    output logic [WIN_W-1:0]    window_now,
    output logic                last_of_run
);

    localparam int               IDX_W   = ID_WIDTH + 1;
    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);
    localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1);

    // Sequencer
    upc_t   upc_reg, upc_next;
    uword_t uw;
    logic   step_go;
    logic   jump_take;

    // Configuration and latched command payload
    logic [TICK_W-1:0]   timeout_reg;
    logic                fin_reg;
    logic [ID_WIDTH-1:0] ack_id_reg;
    logic [1:0]          ack_code_reg;
    logic [WIN_W-1:0]    ack_window_reg;

    // Window state
    logic [ID_WIDTH-1:0] sent_count_reg, sent_count_next;
    logic [ID_WIDTH-1:0] acked_upto_reg, acked_upto_next;
    logic [ID_WIDTH-1:0] resend_next_reg, resend_next_next;
    logic [WIN_W-1:0]    in_flight_reg, in_flight_next;
    logic [WIN_W-1:0]    cong_window_reg, cong_window_next;
    logic [WIN_W-1:0]    peer_window_reg, peer_window_next;
    logic [TICK_W-1:0]   tick_counter_reg, tick_counter_next;
    logic                resend_active_reg, resend_active_next;
    logic                transfer_done_reg, transfer_done_next;
    logic                closing_sent_reg, closing_sent_next;

    // Result register
    logic                res_valid_reg, res_valid_next;
    kind_t               kind_reg, kind_next;
    logic [ID_WIDTH-1:0] packet_id_reg, packet_id_next;
    logic                closing_flag_reg, closing_flag_next;
    logic                slow_pace_reg, slow_pace_next;
    logic [WIN_W-1:0]    window_now_reg, window_now_next;
    logic                last_of_run_reg, last_of_run_next;

    // Datapath conditions
    logic                room;
    logic                burst_ok;
    logic                burst_more;
    logic                refuse_pre;
    logic                ack_stale;
    logic                close_ack;
    logic                settled;
    logic                expired;
    logic [WIN_W-1:0]    in_flight_inc;
    logic [IDX_W-1:0]    resend_inc;
    logic [IDX_W-1:0]    sent_inc;
    logic [IDX_W-1:0]    slow_bound;
    logic [TICK_W-1:0]   tick_inc;
    logic [TICK_W-1:0]   tick_limit;
    logic [ID_WIDTH-1:0] resend_max;

    assign uw = ucode(upc_reg);

    assign cmd_ready = (uw.cond == C_DISPATCH);

    // Emitting steps wait for the result register; the fetch step waits for a command.
    assign step_go = (uw.cond == C_DISPATCH) ? cmd_valid
                                             : !((uw.em != EM_NONE) && res_valid_reg && !res_ready);

    assign in_flight_inc = in_flight_reg + WIN_ONE;
    assign resend_inc    = {1'b0, resend_next_reg} + IDX_W'(1);
    assign sent_inc      = {1'b0, sent_count_reg} + IDX_W'(1);
    assign slow_bound    = {1'b0, acked_upto_reg} + IDX_W'(SLOW_LIMIT);
    assign tick_inc      = tick_counter_reg + TICK_W'(1);
    assign tick_limit    = (timeout_reg == '0) ? TICK_W'(1) : timeout_reg;

    assign room       = (in_flight_reg < cong_window_reg) && (in_flight_reg < peer_window_reg);
    assign burst_ok   = room && (resend_next_reg < sent_count_reg);
    // Whether the burst goes on after the retransmit of this step.
    assign burst_more = (in_flight_inc < cong_window_reg) && (in_flight_inc < peer_window_reg)
                        && (resend_inc < {1'b0, sent_count_reg});
    assign refuse_pre = transfer_done_reg || closing_sent_reg || (&sent_count_reg);
    assign ack_stale  = transfer_done_reg || (ack_id_reg <= acked_upto_reg)
                        || (ack_id_reg > sent_count_reg);
    assign close_ack  = (ack_code_reg == ACK_CODE_CLOSE) && (ack_id_reg == sent_count_reg)
                        && closing_sent_reg;
    assign settled    = (acked_upto_reg == sent_count_reg);
    assign expired    = (tick_inc >= tick_limit);
    assign resend_max = (resend_next_reg < ack_id_reg) ? ack_id_reg : resend_next_reg;

    always_comb
    begin
        case (uw.cond)
            C_JUMP:        jump_take = 1'b1;
            C_REFUSE_PRE:  jump_take = refuse_pre;
            C_RESEND_ACT:  jump_take = resend_active_reg;
            C_FIN:         jump_take = fin_reg;
            C_NO_ROOM:     jump_take = !room;
            C_NOT_SETTLED: jump_take = !settled;
            C_NO_BURST:    jump_take = !burst_ok;
            C_STALE:       jump_take = ack_stale;
            C_CLOSE_ACK:   jump_take = close_ack;
            C_DONE:        jump_take = transfer_done_reg;
            C_NOT_EXPIRED: jump_take = !expired;
            C_SETTLED:     jump_take = settled;
            default:       jump_take = 1'b0;
        endcase

        if (!step_go)
        begin
            upc_next = upc_reg;
        end
        else if (uw.cond == C_DISPATCH)
        begin
            upc_next = dispatch(cmd_t'(command));
        end
        else if (uw.cond == C_LOOP)
        begin
            upc_next = burst_more ? upc_reg : uw.target;
        end
        else
        begin
            upc_next = jump_take ? uw.target : upc_t'(upc_reg + upc_t'(1));
        end
    end

    always_comb
    begin
        sent_count_next    = sent_count_reg;
        acked_upto_next    = acked_upto_reg;
        resend_next_next   = resend_next_reg;
        in_flight_next     = in_flight_reg;
        cong_window_next   = cong_window_reg;
        peer_window_next   = peer_window_reg;
        tick_counter_next  = tick_counter_reg;
        resend_active_next = resend_active_reg;
        transfer_done_next = transfer_done_reg;
        closing_sent_next  = closing_sent_reg;

        if (step_go)
        begin
            case (uw.op)
                OP_CLEAR:
                begin
                    sent_count_next    = '0;
                    acked_upto_next    = '0;
                    resend_next_next   = '0;
                    in_flight_next     = '0;
                    cong_window_next   = WIN_ONE;
                    peer_window_next   = WIN_ONE;
                    tick_counter_next  = '0;
                    resend_active_next = 1'b0;
                    transfer_done_next = 1'b0;
                    closing_sent_next  = 1'b0;
                end
                OP_SEND_DATA:
                begin
                    sent_count_next = sent_inc[ID_WIDTH-1:0];
                    in_flight_next  = in_flight_inc;
                end
                OP_SEND_CLOSE:
                begin
                    sent_count_next   = sent_inc[ID_WIDTH-1:0];
                    closing_sent_next = 1'b1;
                    if (in_flight_reg < WIN_MAX)
                    begin
                        in_flight_next = in_flight_inc;
                    end
                end
                OP_RESEND:
                begin
                    resend_next_next = resend_inc[ID_WIDTH-1:0];
                    in_flight_next   = in_flight_inc;
                end
                OP_END_BURST:
                begin
                    if (resend_next_reg >= sent_count_reg)
                    begin
                        resend_active_next = 1'b0;
                    end
                end
                OP_ACK_DEC:
                begin
                    if (in_flight_reg != '0)
                    begin
                        in_flight_next = in_flight_reg - WIN_ONE;
                    end
                end
                OP_ACK_UPDATE:
                begin
                    if (cong_window_reg < WIN_MAX)
                    begin
                        cong_window_next = cong_window_reg + WIN_ONE;
                    end
                    acked_upto_next  = ack_id_reg;
                    peer_window_next = (ack_window_reg > WIN_MAX) ? WIN_MAX : ack_window_reg;
                    resend_next_next = resend_max;
                    if (resend_max >= sent_count_reg)
                    begin
                        resend_active_next = 1'b0;
                    end
                end
                OP_SET_DONE:
                begin
                    transfer_done_next = 1'b1;
                    resend_active_next = 1'b0;
                end
                OP_TICK_COUNT:
                begin
                    tick_counter_next = expired ? '0 : tick_inc;
                end
                OP_TIMEOUT:
                begin
                    if (cong_window_reg > WIN_ONE)
                    begin
                        cong_window_next = cong_window_reg >> 1;
                    end
                    in_flight_next     = '0;
                    resend_next_next   = acked_upto_reg;
                    resend_active_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next    = res_valid_reg && !res_ready;
        kind_next         = kind_reg;
        packet_id_next    = packet_id_reg;
        closing_flag_next = closing_flag_reg;
        slow_pace_next    = slow_pace_reg;
        window_now_next   = window_now_reg;
        last_of_run_next  = last_of_run_reg;

        if (step_go && (uw.em != EM_NONE))
        begin
            res_valid_next    = 1'b1;
            kind_next         = uw.kind;
            closing_flag_next = (uw.op == OP_SEND_CLOSE);
            slow_pace_next    = (uw.op == OP_SEND_DATA) && (slow_bound < sent_inc);
            // Every result of a command reports the window as it stands after that command.
            window_now_next   = cong_window_next;
            last_of_run_next  = (uw.em == EM_LAST) ? 1'b1 : !burst_more;
            case (uw.kind)
                K_SEND:                 packet_id_next = sent_inc[ID_WIDTH-1:0];
                K_RESEND:               packet_id_next = resend_inc[ID_WIDTH-1:0];
                K_ACK, K_STALE, K_DONE: packet_id_next = ack_id_reg;
                default:                packet_id_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg           <= A_FETCH;
            timeout_reg       <= TIMEOUT_RESET;
            sent_count_reg    <= '0;
            acked_upto_reg    <= '0;
            resend_next_reg   <= '0;
            in_flight_reg     <= '0;
            cong_window_reg   <= WIN_ONE;
            peer_window_reg   <= WIN_ONE;
            tick_counter_reg  <= '0;
            resend_active_reg <= 1'b0;
            transfer_done_reg <= 1'b0;
            closing_sent_reg  <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            upc_reg           <= upc_next;
            sent_count_reg    <= sent_count_next;
            acked_upto_reg    <= acked_upto_next;
            resend_next_reg   <= resend_next_next;
            in_flight_reg     <= in_flight_next;
            cong_window_reg   <= cong_window_next;
            peer_window_reg   <= peer_window_next;
            tick_counter_reg  <= tick_counter_next;
            resend_active_reg <= resend_active_next;
            transfer_done_reg <= transfer_done_next;
            closing_sent_reg  <= closing_sent_next;
            res_valid_reg     <= res_valid_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            fin_reg        <= final_packet;
            ack_id_reg     <= ack_id;
            ack_code_reg   <= ack_code;
            ack_window_reg <= ack_window;
        end
        kind_reg         <= kind_next;
        packet_id_reg    <= packet_id_next;
        closing_flag_reg <= closing_flag_next;
        slow_pace_reg    <= slow_pace_next;
        window_now_reg   <= window_now_next;
        last_of_run_reg  <= last_of_run_next;
    end

    assign res_valid    = res_valid_reg;
    assign kind         = kind_reg;
    assign packet_id    = packet_id_reg;
    assign closing_flag = closing_flag_reg;
    assign slow_pace    = slow_pace_reg;
    assign window_now   = window_now_reg;
    assign last_of_run  = last_of_run_reg;

endmodule

// ===== sv/gbnsw_check.sv =====
// Port-level assertions for the sender window, bound to the top level.
`timescale 1ns / 1ps
`include "go_back_n_sender_window_assert.svh"

module gbnsw_check import gbnsw_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input logic             res_valid,
    input logic             res_ready,
    input kind_t            kind,
    input logic [WIN_W-1:0] window_now,
    input logic             last_of_run
);

    logic             res_stall;
    logic [WIN_W+3:0] res_view;

    assign res_stall = res_valid && !res_ready;
    assign res_view  = {kind, window_now, last_of_run};

    // One command is worked on at a time.
    `GBNSW_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready, "busy but ready")

    // When a new command can be taken, the result still waiting closes its run.
    `GBNSW_ASSERT_NOW(a_ready_run_closed, cmd_ready && res_valid, last_of_run, "run left open")

    // Only a retransmit burst yields more than one result per command.
    `GBNSW_ASSERT_NOW(a_run_is_burst, res_valid && !last_of_run, kind == K_RESEND, "not a burst")

    `GBNSW_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_view), "result changed")

endmodule

bind go_back_n_sender_window gbnsw_check u_gbnsw_check (.*);

// ===== sim/tb_top.sv =====
// Self-checking bench for the Go-Back-N sender window: directed cases and random traffic.
`timescale 1ns / 1ps

module tb_top;
    import gbnsw_pkg::*;

    localparam logic [WIN_W-1:0]        WMAX   = WIN_W'(MAX_WINDOW_DEF);
    localparam logic [ID_WIDTH_DEF-1:0] ID_TOP = {ID_WIDTH_DEF{1'b1}};

    typedef struct {
        cmd_t                    op;
        logic                    closing;
        logic [ID_WIDTH_DEF-1:0] ack_id;
        logic [1:0]              code;
        logic [WIN_W-1:0]        credit;
    } command_item_t;

    typedef struct {
        kind_t                   kind;
        logic [ID_WIDTH_DEF-1:0] id;
        logic                    closing;
        logic                    slow;
        logic [WIN_W-1:0]        window;
        logic                    last;
    } outcome_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [TICK_W-1:0]       cfg_wr_data = '0;
    logic                    cmd_valid = 1'b0;
    logic                    cmd_ready;
    logic [1:0]              command = '0;
    logic                    final_packet = 1'b0;
    logic [ID_WIDTH_DEF-1:0] ack_id = '0;
    logic [1:0]              ack_code = '0;
    logic [WIN_W-1:0]        ack_window = '0;
    logic                    res_valid;
    logic                    res_ready = 1'b0;
    kind_t                   kind;
    logic [ID_WIDTH_DEF-1:0] packet_id;
    logic                    closing_flag;
    logic                    slow_pace;
    logic [WIN_W-1:0]        window_now;
    logic                    last_of_run;

    // Shadow of the sender window state.
    logic [ID_WIDTH_DEF-1:0] next_id = '0;
    logic [ID_WIDTH_DEF-1:0] acked_id = '0;
    logic [WIN_W-1:0]        outstanding = '0;
    logic [WIN_W-1:0]        cwnd = WIN_W'(1);
    logic [WIN_W-1:0]        rwnd = WIN_W'(1);
    logic [TICK_W-1:0]       tick_cnt = '0;
    logic [ID_WIDTH_DEF-1:0] resend_id = '0;
    logic                    resend_pending = 1'b0;
    logic                    closed = 1'b0;
    logic                    close_sent = 1'b0;
    logic [TICK_W-1:0]       tick_limit = TIMEOUT_RESET;

    command_item_t pending_q[$];
    command_item_t drive_item;
    outcome_t      step_buf[$];
    outcome_t      outcome_q[$];
    outcome_t      want;

    int  cmds_queued = 0;
    int  cmds_taken = 0;
    int  mismatches = 0;
    int  idle_pct = 0;
    int  send_gap = 0;
    int  take_gap = 0;
    logic cmd_fire = 1'b0;

    go_back_n_sender_window u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .command      (command),
        .final_packet (final_packet),
        .ack_id       (ack_id),
        .ack_code     (ack_code),
        .ack_window   (ack_window),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .kind         (kind),
        .packet_id    (packet_id),
        .closing_flag (closing_flag),
        .slow_pace    (slow_pace),
        .window_now   (window_now),
        .last_of_run  (last_of_run)
    );

    always #4 clk = ~clk;

    function automatic logic window_open();
        return (outstanding < cwnd) && (outstanding < rwnd);
    endfunction

    function automatic void push_outcome(kind_t k, logic [ID_WIDTH_DEF-1:0] id,
                                         logic closing, logic slow);
        outcome_t o;
        o.kind = k;
        o.id = id;
        o.closing = closing;
        o.slow = slow;
        o.window = '0;
        o.last = 1'b0;
        step_buf.push_back(o);
    endfunction

    // Go back to the last ack and resend as far as the window allows.
    function automatic void resend_burst();
        while (resend_pending && window_open() && resend_id < next_id
               && step_buf.size() < MAX_WINDOW_DEF)
        begin
            resend_id++;
            outstanding++;
            push_outcome(K_RESEND, resend_id, 1'b0, 1'b0);
        end
        if (resend_id >= next_id)
            resend_pending = 1'b0;
    endfunction

    function automatic void predict_window_step(cmd_t op, logic fin,
                                                logic [ID_WIDTH_DEF-1:0] aid,
                                                logic [1:0] code, logic [WIN_W-1:0] credit);
        outcome_t o;
        case (op)
            CMD_START:
            begin
                next_id = '0;
                acked_id = '0;
                outstanding = '0;
                cwnd = WIN_W'(1);
                rwnd = WIN_W'(1);
                tick_cnt = '0;
                resend_id = '0;
                resend_pending = 1'b0;
                closed = 1'b0;
                close_sent = 1'b0;
            end
            CMD_OFFER:
            begin
                if (closed || close_sent || next_id >= ID_TOP)
                    push_outcome(K_REFUSED, '0, 1'b0, 1'b0);
                else if (resend_pending)
                begin
                    resend_burst();
                    if (step_buf.size() == 0)
                        push_outcome(K_REFUSED, '0, 1'b0, 1'b0);
                end
                else if (fin)
                begin
                    // The closing packet goes out only when everything is acked.
                    if (acked_id != next_id)
                        push_outcome(K_REFUSED, '0, 1'b0, 1'b0);
                    else
                    begin
                        next_id++;
                        if (outstanding < WMAX)
                            outstanding++;
                        close_sent = 1'b1;
                        push_outcome(K_SEND, next_id, 1'b1, 1'b0);
                    end
                end
                else if (!window_open())
                    push_outcome(K_REFUSED, '0, 1'b0, 1'b0);
                else
                begin
                    next_id++;
                    outstanding++;
                    push_outcome(K_SEND, next_id, 1'b0,
                                 (int'(acked_id) + SLOW_LIMIT) < int'(next_id));
                end
            end
            CMD_ACK:
            begin
                if (outstanding != 0)
                    outstanding--;
                if (closed || aid <= acked_id || aid > next_id)
                    push_outcome(K_STALE, aid, 1'b0, 1'b0);
                else
                begin
                    if (cwnd < WMAX)
                        cwnd++;
                    acked_id = aid;
                    rwnd = (credit > WMAX) ? WMAX : credit;
                    if (resend_id < acked_id)
                        resend_id = acked_id;
                    if (resend_id >= next_id)
                        resend_pending = 1'b0;
                    if (code == ACK_CODE_CLOSE && aid == next_id && close_sent)
                    begin
                        closed = 1'b1;
                        resend_pending = 1'b0;
                        push_outcome(K_DONE, aid, 1'b0, 1'b0);
                    end
                    else
                        push_outcome(K_ACK, aid, 1'b0, 1'b0);
                end
            end
            default:
            begin
                if (!closed)
                begin
                    tick_cnt = tick_cnt + TICK_W'(1);
                    if (tick_cnt >= ((tick_limit == 0) ? TICK_W'(1) : tick_limit))
                    begin
                        tick_cnt = '0;
                        if (acked_id != next_id)
                        begin
                            if (cwnd > 1)
                                cwnd = cwnd >> 1;
                            outstanding = '0;
                            resend_id = acked_id;
                            resend_pending = 1'b1;
                            resend_burst();
                        end
                    end
                end
            end
        endcase
        if (step_buf.size() == 0)
            push_outcome(K_IDLE, '0, 1'b0, 1'b0);
        while (step_buf.size() != 0)
        begin
            o = step_buf.pop_front();
            o.window = cwnd;
            o.last = (step_buf.size() == 0);
            outcome_q.push_back(o);
        end
    endfunction

    function automatic void queue_cmd(cmd_t op, logic fin, logic [ID_WIDTH_DEF-1:0] id,
                                      logic [1:0] code, logic [WIN_W-1:0] credit);
        command_item_t c;
        c.op = op;
        c.closing = fin;
        c.ack_id = id;
        c.code = code;
        c.credit = credit;
        pending_q.push_back(c);
        cmds_queued++;
    endfunction

    function automatic logic [WIN_W-1:0] random_credit();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return WIN_W'($urandom_range(0, 7));
        else if (p < 3)
            return WIN_W'($urandom_range(MAX_WINDOW_DEF + 1, 127));
        return WIN_W'($urandom_range(16, MAX_WINDOW_DEF));
    endfunction

    // Command driver: a new transfer is offered once the previous one is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                drive_item = pending_q.pop_front();
                cmd_valid <= 1'b1;
                command <= drive_item.op;
                final_packet <= drive_item.closing;
                ack_id <= drive_item.ack_id;
                ack_code <= drive_item.code;
                ack_window <= drive_item.credit;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    send_gap = $urandom_range(1, 9);
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (take_gap > 0)
        begin
            take_gap--;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                take_gap = $urandom_range(1, 9);
        end
    end

    // Result checker and predictor, both on the rising edge.
    always @(posedge clk)
    begin
        cmd_fire <= cmd_valid && cmd_ready;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, actual kind %0d id %0d", $time, kind,
                             packet_id);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (kind !== want.kind || packet_id !== want.id
                        || closing_flag !== want.closing || slow_pace !== want.slow
                        || window_now !== want.window || last_of_run !== want.last)
                    begin
                        mismatches++;
                        $display({"%0t: expected kind %0d id %0d close %b slow %b ",
                                  "win %0d last %b, actual kind %0d id %0d close %b ",
                                  "slow %b win %0d last %b"}, $time,
                                 want.kind, want.id, want.closing, want.slow,
                                 want.window, want.last, kind, packet_id,
                                 closing_flag, slow_pace, window_now, last_of_run);
                    end
                end
            end
            if (cfg_wr_en)
                tick_limit = cfg_wr_data;
            if (cmd_valid && cmd_ready)
            begin
                predict_window_step(cmd_t'(command), final_packet, ack_id, ack_code,
                                    ack_window);
                cmds_taken++;
            end
        end
    end

    task automatic drain();
        while (cmds_taken != cmds_queued || outcome_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TICK_W-1:0] ticks);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed traffic in chunks; each chunk ends with the sender
    // holding off until every result is back, so acks can track real ids.
    task automatic random_traffic(input int count);
        int first;
        int est_sent;
        int est_acked;
        int est_out;
        int est_room;
        int pick;
        logic [ID_WIDTH_DEF-1:0] aid;
        first = cmds_queued;
        while (cmds_queued - first < count)
        begin
            est_sent = int'(next_id);
            est_acked = int'(acked_id);
            est_out = int'(outstanding);
            est_room = (cwnd < rwnd) ? int'(cwnd) : int'(rwnd);
            if (closed && $urandom_range(0, 3) != 0)
            begin
                queue_cmd(CMD_START, 1'($urandom), ID_WIDTH_DEF'($urandom), 2'($urandom),
                          WIN_W'($urandom));
                est_sent = 0;
                est_acked = 0;
                est_out = 0;
                est_room = 1;
            end
            repeat ($urandom_range(8, 24))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    queue_cmd(CMD_OFFER, $urandom_range(0, 19) == 0, ID_WIDTH_DEF'($urandom),
                              2'($urandom), WIN_W'($urandom));
                    if (est_out < est_room)
                    begin
                        est_sent++;
                        est_out++;
                    end
                end
                else if (pick < 75)
                begin
                    if (pick < 69 && est_sent > est_acked)
                    begin
                        aid = $urandom_range(0, 1)
                              ? ID_WIDTH_DEF'(est_sent)
                              : ID_WIDTH_DEF'($urandom_range(est_acked + 1, est_sent));
                        est_acked = int'(aid);
                        est_room++;
                    end
                    else if (pick < 72)
                        aid = ID_WIDTH_DEF'($urandom);
                    else
                        aid = ID_WIDTH_DEF'($urandom_range(0, est_acked));
                    queue_cmd(CMD_ACK, 1'($urandom), aid,
                              ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'd0,
                              random_credit());
                    if (est_out > 0)
                        est_out--;
                end
                else if (pick < 92)
                    queue_cmd(CMD_TICK, 1'($urandom), ID_WIDTH_DEF'($urandom), 2'($urandom),
                              WIN_W'($urandom));
                else if (pick < 97)
                begin
                    // Ack everything, send the closing packet, then close it.
                    if (est_sent > est_acked)
                        queue_cmd(CMD_ACK, 1'b0, ID_WIDTH_DEF'(est_sent), 2'd0,
                                  random_credit());
                    queue_cmd(CMD_OFFER, 1'b1, ID_WIDTH_DEF'($urandom), 2'($urandom),
                              WIN_W'($urandom));
                    est_sent++;
                    queue_cmd(CMD_ACK, 1'b0, ID_WIDTH_DEF'(est_sent), ACK_CODE_CLOSE,
                              random_credit());
                    est_acked = est_sent;
                end
                else
                begin
                    queue_cmd(CMD_START, 1'($urandom), ID_WIDTH_DEF'($urandom), 2'($urandom),
                              WIN_W'($urandom));
                    est_sent = 0;
                    est_acked = 0;
                    est_out = 0;
                    est_room = 1;
                end
            end
            drain();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed cases; a timeout of zero makes every tick a timeout check.
        write_timeout('0);
        idle_pct = 30;
        queue_cmd(CMD_START, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_TICK, 1'b1, ID_TOP, 2'd3, 7'h7F);
        queue_cmd(CMD_ACK, 1'b0, '0, 2'd0, 7'd1);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_OFFER, 1'b1, '0, 2'd0, '0);
        queue_cmd(CMD_ACK, 1'b0, 16'd5, 2'd0, 7'd3);
        queue_cmd(CMD_ACK, 1'b0, 16'd1, 2'd0, 7'h7F);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_TICK, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_ACK, 1'b0, 16'd2, 2'd2, 7'd0);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_TICK, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_ACK, 1'b0, 16'd3, 2'd3, WMAX);
        queue_cmd(CMD_OFFER, 1'b1, '0, 2'd0, '0);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_ACK, 1'b0, 16'd4, ACK_CODE_CLOSE, WMAX);
        queue_cmd(CMD_TICK, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_ACK, 1'b0, 16'd4, ACK_CODE_CLOSE, WMAX);
        queue_cmd(CMD_OFFER, 1'b0, '0, 2'd0, '0);
        queue_cmd(CMD_START, 1'b1, ID_TOP, 2'd3, 7'h7F);
        drain();

        write_timeout(32'd3);
        idle_pct = 25;
        random_traffic(100);

        write_timeout(32'd1);
        idle_pct = 45;
        random_traffic(100);

        write_timeout(TIMEOUT_RESET);
        idle_pct = 15;
        random_traffic(100);

        // The last part runs with no idling on either side.
        write_timeout({TICK_W{1'b1}});
        idle_pct = 0;
        random_traffic(100);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
